// ===== hdl/wsia_pkg.sv =====
// ----------------------------------------------------------------------------
// wsia_pkg: shared types, constants and helpers
// Opcodes, the context record carried down the pipe, and width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wsia_pkg;

    localparam int DATA_W    = 64;
    localparam int MAX_WIDTH = 64;
    localparam int CNT_W     = $clog2(DATA_W) + 1;
    localparam int IDX_W     = $clog2(DATA_W);
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 72;

    typedef enum logic [5:0] {
        OP_ADD        = 6'd0,
        OP_SUB        = 6'd1,
        OP_MUL        = 6'd2,
        OP_SDIV       = 6'd3,
        OP_UDIV       = 6'd4,
        OP_SREM       = 6'd5,
        OP_UREM       = 6'd6,
        OP_AND        = 6'd7,
        OP_OR         = 6'd8,
        OP_XOR        = 6'd9,
        OP_NEG        = 6'd10,
        OP_SHL        = 6'd11,
        OP_LSHR       = 6'd12,
        OP_ASHR       = 6'd13,
        OP_SADD_SAT   = 6'd14,
        OP_UADD_SAT   = 6'd15,
        OP_SSUB_SAT   = 6'd16,
        OP_USUB_SAT   = 6'd17,
        OP_SMUL_SAT   = 6'd18,
        OP_UMUL_SAT   = 6'd19,
        OP_SSHL_SAT   = 6'd20,
        OP_USHL_SAT   = 6'd21,
        OP_SDIV_SAT   = 6'd22,
        OP_SCMP       = 6'd23,
        OP_UCMP       = 6'd24,
        OP_SMIN       = 6'd25,
        OP_UMIN       = 6'd26,
        OP_SMAX       = 6'd27,
        OP_UMAX       = 6'd28,
        OP_TRUNC_SSAT = 6'd29,
        OP_TRUNC_USAT = 6'd30,
        OP_ZEXT       = 6'd31,
        OP_SEXT       = 6'd32,
        OP_CLZ        = 6'd33,
        OP_CLO        = 6'd34,
        OP_CTZ        = 6'd35,
        OP_POPCOUNT   = 6'd36
    } op_t;

    // carried alongside the divider
    typedef struct packed {
        op_t               op;
        logic [1:0]        wsel;
        logic [1:0]        tsel;
        logic              sa;
        logic              sb;
        logic              bzero;
        logic              sdiv_ovf;
        logic [DATA_W-1:0] misc_r;
        logic              misc_ovf;
        logic [DATA_W-1:0] prod_lo;
        logic [DATA_W-1:0] prod_hi;
    } ctx_t;

    function automatic logic [CNT_W-1:0] width_of(input logic [1:0] sel);
        logic [CNT_W-1:0] w;
        w = CNT_W'(8) << sel;
        if (w > CNT_W'(MAX_WIDTH)) begin
            w = CNT_W'(MAX_WIDTH);
        end
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] mask_of(input logic [1:0] sel);
        logic [CNT_W-1:0] w;
        w = width_of(sel);
        if (w >= CNT_W'(DATA_W)) begin
            return '1;
        end
        return (DATA_W'(1) << w) - DATA_W'(1);
    endfunction

    function automatic logic msb_of(input logic [DATA_W-1:0] v, input logic [1:0] sel);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(width_of(sel) - CNT_W'(1));
        return v[idx];
    endfunction

    function automatic logic [DATA_W-1:0] sext_of(input logic [DATA_W-1:0] v,
                                                  input logic [1:0] sel);
        logic [DATA_W-1:0] m;
        m = mask_of(sel);
        return msb_of(v, sel) ? (v | ~m) : (v & m);
    endfunction

    function automatic logic [DATA_W-1:0] smax_of(input logic [1:0] sel);
        return mask_of(sel) >> 1;
    endfunction

    function automatic logic [DATA_W-1:0] smin_of(input logic [1:0] sel);
        logic [IDX_W-1:0] sh;
        sh = IDX_W'(width_of(sel) - CNT_W'(1));
        return DATA_W'(1) << sh;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/wsia_logic.sv =====
// ----------------------------------------------------------------------------
// wsia_logic: add/sub, logic, shift, compare, convert and bit-count ops
// Two register stages: raw terms first, then selection and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module wsia_logic (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire wsia_pkg::op_t                 op,
    input  wire logic [1:0]                    wsel,
    input  wire logic [1:0]                    tsel,
    input  wire logic [wsia_pkg::DATA_W-1:0]   a,
    input  wire logic [wsia_pkg::DATA_W-1:0]   b,
    input  wire logic                          sa,
    input  wire logic                          sb,
    output logic      [wsia_pkg::DATA_W-1:0]   res,
    output logic                               ovf
);

    localparam int DW = wsia_pkg::DATA_W;
    localparam int CW = wsia_pkg::CNT_W;
    localparam int IW = wsia_pkg::IDX_W;

    function automatic logic [CW-1:0] lead_zeros(input logic [DW-1:0] v,
                                                 input logic [CW-1:0] w);
        logic [CW-1:0] n;
        n = w;
        for (int i = 0; i < DW; i++) begin
            if (i < int'(w) && v[i]) begin
                n = CW'(int'(w) - 1 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [CW-1:0] trail_zeros(input logic [DW-1:0] v,
                                                  input logic [CW-1:0] w);
        logic [CW-1:0] n;
        n = w;
        for (int i = DW - 1; i >= 0; i--) begin
            if (i < int'(w) && v[i]) begin
                n = CW'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [CW-1:0] pop_count(input logic [DW-1:0] v);
        logic [CW-1:0] n;
        n = '0;
        for (int i = 0; i < DW; i++) begin
            n = n + CW'(v[i]);
        end
        return n;
    endfunction

    // stage B terms
    logic [CW-1:0]      w;
    logic [DW-1:0]      m, tm, ea, eb;
    logic [IW-1:0]      sh;
    logic signed [DW-1:0] eas;
    logic [DW-1:0]      sum_next, diff_next, neg_next, shl_next, lshr_next, ashr_next;
    logic [DW-1:0]      et_next;
    logic               big_next, slt_next, sgt_next, ult_next, ugt_next;
    logic               sfit_next, ufit_next;
    logic [CW-1:0]      clz_next, clo_next, ctz_next, pop_next;

    wsia_pkg::op_t      op_reg;
    logic [1:0]         wsel_reg, tsel_reg;
    logic [DW-1:0]      a_reg, b_reg;
    logic               sa_reg, sb_reg;
    logic [DW-1:0]      sum_reg, diff_reg, neg_reg, shl_reg, lshr_reg, ashr_reg, et_reg;
    logic               big_reg, slt_reg, sgt_reg, ult_reg, ugt_reg, sfit_reg, ufit_reg;
    logic [CW-1:0]      clz_reg, clo_reg, ctz_reg, pop_reg;

    always_comb begin
        w         = wsia_pkg::width_of(wsel);
        m         = wsia_pkg::mask_of(wsel);
        tm        = wsia_pkg::mask_of(tsel);
        ea        = wsia_pkg::sext_of(a, wsel);
        eb        = wsia_pkg::sext_of(b, wsel);
        eas       = signed'(ea);
        sh        = b[IW-1:0];
        sum_next  = (a + b) & m;
        diff_next = (a - b) & m;
        neg_next  = (DW'(0) - a) & m;
        shl_next  = (a << sh) & m;
        lshr_next = a >> sh;
        ashr_next = DW'(eas >>> sh) & m;
        big_next  = b >= DW'(w);
        slt_next  = signed'(ea) < signed'(eb);
        sgt_next  = signed'(ea) > signed'(eb);
        ult_next  = a < b;
        ugt_next  = a > b;
        et_next   = ea & tm;
        sfit_next = (wsia_pkg::width_of(tsel) >= CW'(DW))
                    || (wsia_pkg::sext_of(ea, tsel) == ea);
        ufit_next = a <= tm;
        clz_next  = lead_zeros(a, w);
        clo_next  = lead_zeros(~a & m, w);
        ctz_next  = trail_zeros(a, w);
        pop_next  = pop_count(a);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg   <= op;
            wsel_reg <= wsel;
            tsel_reg <= tsel;
            a_reg    <= a;
            b_reg    <= b;
            sa_reg   <= sa;
            sb_reg   <= sb;
            sum_reg  <= sum_next;
            diff_reg <= diff_next;
            neg_reg  <= neg_next;
            shl_reg  <= shl_next;
            lshr_reg <= lshr_next;
            ashr_reg <= ashr_next;
            et_reg   <= et_next;
            big_reg  <= big_next;
            slt_reg  <= slt_next;
            sgt_reg  <= sgt_next;
            ult_reg  <= ult_next;
            ugt_reg  <= ugt_next;
            sfit_reg <= sfit_next;
            ufit_reg <= ufit_next;
            clz_reg  <= clz_next;
            clo_reg  <= clo_next;
            ctz_reg  <= ctz_next;
            pop_reg  <= pop_next;
        end
    end

    // stage C: select and saturate
    logic [DW-1:0] m_c, sat_s, shl_wrap, res_next;
    logic [CW-1:0] cnt;
    logic          azero, sshl_ovf, ushl_ovf, ovf_next;

    always_comb begin
        m_c      = wsia_pkg::mask_of(wsel_reg);
        sat_s    = sa_reg ? wsia_pkg::smin_of(wsel_reg) : wsia_pkg::smax_of(wsel_reg);
        azero    = a_reg == '0;
        cnt      = CW'(b_reg[IW-1:0]);
        shl_wrap = big_reg ? '0 : shl_reg;
        sshl_ovf = big_reg ? !azero
                 : (sa_reg ? (cnt >= clo_reg) : (!azero && cnt >= clz_reg));
        ushl_ovf = big_reg ? !azero : (cnt > clz_reg);
        res_next = '0;
        ovf_next = 1'b0;
        case (op_reg)
            wsia_pkg::OP_ADD, wsia_pkg::OP_SADD_SAT: begin
                ovf_next = (sa_reg == sb_reg)
                           && (wsia_pkg::msb_of(sum_reg, wsel_reg) != sa_reg);
                res_next = (op_reg == wsia_pkg::OP_SADD_SAT && ovf_next) ? sat_s : sum_reg;
            end
            wsia_pkg::OP_SUB, wsia_pkg::OP_SSUB_SAT: begin
                ovf_next = (sa_reg != sb_reg)
                           && (wsia_pkg::msb_of(diff_reg, wsel_reg) != sa_reg);
                res_next = (op_reg == wsia_pkg::OP_SSUB_SAT && ovf_next) ? sat_s : diff_reg;
            end
            wsia_pkg::OP_AND: res_next = a_reg & b_reg;
            wsia_pkg::OP_OR:  res_next = a_reg | b_reg;
            wsia_pkg::OP_XOR: res_next = a_reg ^ b_reg;
            wsia_pkg::OP_NEG: begin
                res_next = neg_reg;
                ovf_next = a_reg == wsia_pkg::smin_of(wsel_reg);
            end
            wsia_pkg::OP_SHL: begin
                res_next = shl_wrap;
                ovf_next = sshl_ovf;
            end
            wsia_pkg::OP_SSHL_SAT: begin
                ovf_next = sshl_ovf;
                res_next = sshl_ovf ? sat_s : shl_wrap;
            end
            wsia_pkg::OP_USHL_SAT: begin
                ovf_next = ushl_ovf;
                res_next = ushl_ovf ? m_c : shl_wrap;
            end
            wsia_pkg::OP_LSHR: res_next = big_reg ? '0 : lshr_reg;
            wsia_pkg::OP_ASHR: res_next = big_reg ? (sa_reg ? m_c : '0) : ashr_reg;
            wsia_pkg::OP_UADD_SAT: begin
                ovf_next = sum_reg < b_reg;
                res_next = ovf_next ? m_c : sum_reg;
            end
            wsia_pkg::OP_USUB_SAT: begin
                ovf_next = ult_reg;
                res_next = ult_reg ? '0 : diff_reg;
            end
            wsia_pkg::OP_SCMP: res_next = slt_reg ? m_c : DW'(sgt_reg);
            wsia_pkg::OP_UCMP: res_next = ult_reg ? m_c : DW'(ugt_reg);
            wsia_pkg::OP_SMIN: res_next = sgt_reg ? b_reg : a_reg;
            wsia_pkg::OP_SMAX: res_next = slt_reg ? b_reg : a_reg;
            wsia_pkg::OP_UMIN: res_next = ugt_reg ? b_reg : a_reg;
            wsia_pkg::OP_UMAX: res_next = ult_reg ? b_reg : a_reg;
            wsia_pkg::OP_TRUNC_SSAT: begin
                ovf_next = !sfit_reg;
                res_next = sfit_reg ? et_reg
                         : (sa_reg ? wsia_pkg::smin_of(tsel_reg)
                                   : wsia_pkg::smax_of(tsel_reg));
            end
            wsia_pkg::OP_TRUNC_USAT: begin
                ovf_next = !ufit_reg;
                res_next = ufit_reg ? a_reg : wsia_pkg::mask_of(tsel_reg);
            end
            wsia_pkg::OP_ZEXT:     res_next = a_reg & wsia_pkg::mask_of(tsel_reg);
            wsia_pkg::OP_SEXT:     res_next = et_reg;
            wsia_pkg::OP_CLZ:      res_next = DW'(clz_reg);
            wsia_pkg::OP_CLO:      res_next = DW'(clo_reg);
            wsia_pkg::OP_CTZ:      res_next = DW'(ctz_reg);
            wsia_pkg::OP_POPCOUNT: res_next = DW'(pop_reg);
            default: begin
                res_next = '0;
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res <= res_next;
            ovf <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wsia_mul.sv =====
// ----------------------------------------------------------------------------
// wsia_mul: 64x64 unsigned multiplier, two stages
// Four 32x32 partial products, then one registered 128-bit sum.
// ----------------------------------------------------------------------------
`default_nettype none

module wsia_mul (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [wsia_pkg::DATA_W-1:0]   x,
    input  wire logic [wsia_pkg::DATA_W-1:0]   y,
    output logic      [wsia_pkg::DATA_W-1:0]   lo,
    output logic      [wsia_pkg::DATA_W-1:0]   hi
);

    localparam int DW = wsia_pkg::DATA_W;
    localparam int HW = DW / 2;

    logic [DW-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic [DW-1:0]   p00_next, p01_next, p10_next, p11_next;
    logic [2*DW-1:0] prod_reg, prod_next;

    always_comb begin
        p00_next  = DW'(x[HW-1:0])  * DW'(y[HW-1:0]);
        p01_next  = DW'(x[HW-1:0])  * DW'(y[DW-1:HW]);
        p10_next  = DW'(x[DW-1:HW]) * DW'(y[HW-1:0]);
        p11_next  = DW'(x[DW-1:HW]) * DW'(y[DW-1:HW]);
        prod_next = (2*DW)'(p00_reg)
                  + ((2*DW)'(p01_reg) << HW)
                  + ((2*DW)'(p10_reg) << HW)
                  + ((2*DW)'(p11_reg) << DW);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg  <= p00_next;
            p01_reg  <= p01_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            prod_reg <= prod_next;
        end
    end

    assign lo = prod_reg[DW-1:0];
    assign hi = prod_reg[2*DW-1:DW];

endmodule

`default_nettype wire

// ===== hdl/wsia_div.sv =====
// ----------------------------------------------------------------------------
// wsia_div: pipelined restoring divider
// One quotient bit per stage; the context record rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module wsia_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire logic [wsia_pkg::DATA_W-1:0]   dvd,
    input  wire logic [wsia_pkg::DATA_W-1:0]   dvs,
    input  wire wsia_pkg::ctx_t                ctx_in,
    output logic                               out_vld,
    output logic      [wsia_pkg::DATA_W-1:0]   quo,
    output logic      [wsia_pkg::DATA_W-1:0]   rem,
    output wsia_pkg::ctx_t                     ctx_out
);

    localparam int DW     = wsia_pkg::DATA_W;
    localparam int STAGES = wsia_pkg::DATA_W;

    logic [DW-1:0]  rem_reg [STAGES];
    logic [DW-1:0]  quo_reg [STAGES];
    logic [DW-1:0]  dvs_reg [STAGES];
    wsia_pkg::ctx_t ctx_reg [STAGES];
    logic           vld_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic [DW-1:0]  rem_in, quo_in, dvs_in, rem_next, quo_next;
        logic [DW:0]    trial, diff;
        wsia_pkg::ctx_t ctx_in_s;
        logic           vld_in, ge;

        if (i == 0) begin : g_first
            assign rem_in   = '0;
            assign quo_in   = dvd;
            assign dvs_in   = dvs;
            assign ctx_in_s = ctx_in;
            assign vld_in   = in_vld;
        end else begin : g_next
            assign rem_in   = rem_reg[i-1];
            assign quo_in   = quo_reg[i-1];
            assign dvs_in   = dvs_reg[i-1];
            assign ctx_in_s = ctx_reg[i-1];
            assign vld_in   = vld_reg[i-1];
        end

        always_comb begin
            trial    = {rem_in, quo_in[DW-1]};
            diff     = trial - {1'b0, dvs_in};
            ge       = trial >= {1'b0, dvs_in};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_in[DW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                quo_reg[i] <= quo_next;
                dvs_reg[i] <= dvs_in;
                ctx_reg[i] <= ctx_in_s;
            end
        end
    end

    assign out_vld = vld_reg[STAGES-1];
    assign quo     = quo_reg[STAGES-1];
    assign rem     = rem_reg[STAGES-1];
    assign ctx_out = ctx_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/width_selectable_integer_alu.sv =====
// ----------------------------------------------------------------------------
// width_selectable_integer_alu: pipelined integer ALU, 8/16/32/64-bit
// Wrapping, saturating, divide, compare, convert and bit-count operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata: opcode, operand width,
//   two operands and a target width. Each beat yields exactly one result
//   beat on m_tvalid/m_tready/m_tdata: the value masked to the result width,
//   an overflow flag and a divide-by-zero flag.
//   The path from accept to m_tvalid holds one input register, two stages
//   for the partial-product multiplier and the other operations, 64
//   restoring-divider stages (one quotient bit each), one output register.
//   Every operation takes the same path, so results leave in input order.
//   One beat per cycle unless m_tready stalls; the divider sets the latency.
//   A stall on m_tready freezes the whole pipe in place; s_tready drops in
//   the same cycle, so nothing is lost or repeated. The output register
//   empties into a ready receiver while the next beat is accepted.
//   Reset (aresetn low, synchronous) clears all valid bits; payload
//   registers are not reset.
//   Division by zero returns zero with div_zero set.
// ----------------------------------------------------------------------------
`default_nettype none

module width_selectable_integer_alu (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [5:0] op, [7:6] width_sel, [71:8] operand_a, [135:72] operand_b,
    // [137:136] target_width_sel, rest zero
    input  wire logic [wsia_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [63:0] result, [64] overflow, [65] div_zero, rest zero
    output logic      [wsia_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int DW = wsia_pkg::DATA_W;

    logic adv;  // whole pipe moves together

    // ---- stage A: capture, mask, magnitudes ----
    wsia_pkg::op_t in_op;
    logic [1:0]    in_wsel, in_tsel;
    logic [DW-1:0] in_m, in_a, in_b, in_ea, in_eb, mag_a, mag_b;
    logic          in_sa, in_sb, in_sdiv;

    wsia_pkg::op_t op_a_reg, op_b_reg, op_c_reg;
    logic [1:0]    wsel_a_reg, wsel_b_reg, wsel_c_reg;
    logic [1:0]    tsel_a_reg, tsel_b_reg, tsel_c_reg;
    logic          sa_a_reg, sa_b_reg, sa_c_reg;
    logic          sb_a_reg, sb_b_reg, sb_c_reg;
    logic          bz_a_reg, bz_b_reg, bz_c_reg;
    logic          sdo_a_reg, sdo_b_reg, sdo_c_reg;
    logic [DW-1:0] dvd_a_reg, dvd_b_reg, dvd_c_reg;
    logic [DW-1:0] dvs_a_reg, dvs_b_reg, dvs_c_reg;
    logic [DW-1:0] a_a_reg, b_a_reg, mx_a_reg, my_a_reg;
    logic          vld_a_reg, vld_b_reg, vld_c_reg;

    logic [DW-1:0] dvd_next, dvs_next, mx_next, my_next;
    logic          bz_next, sdo_next;

    always_comb begin
        in_op    = wsia_pkg::op_t'(s_tdata[5:0]);
        in_wsel  = s_tdata[7:6];
        in_tsel  = s_tdata[137:136];
        in_m     = wsia_pkg::mask_of(in_wsel);
        in_a     = s_tdata[71:8] & in_m;
        in_b     = s_tdata[135:72] & in_m;
        in_ea    = wsia_pkg::sext_of(in_a, in_wsel);
        in_eb    = wsia_pkg::sext_of(in_b, in_wsel);
        in_sa    = wsia_pkg::msb_of(in_a, in_wsel);
        in_sb    = wsia_pkg::msb_of(in_b, in_wsel);
        mag_a    = in_sa ? (DW'(0) - in_ea) : in_ea;
        mag_b    = in_sb ? (DW'(0) - in_eb) : in_eb;
        in_sdiv  = in_op inside {wsia_pkg::OP_SDIV, wsia_pkg::OP_SREM, wsia_pkg::OP_SDIV_SAT};
        dvd_next = in_sdiv ? mag_a : in_a;
        dvs_next = in_sdiv ? mag_b : in_b;
        mx_next  = (in_op == wsia_pkg::OP_UMUL_SAT) ? in_a : mag_a;
        my_next  = (in_op == wsia_pkg::OP_UMUL_SAT) ? in_b : mag_b;
        bz_next  = in_b == '0;
        sdo_next = (in_a == wsia_pkg::smin_of(in_wsel)) && (in_b == in_m);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end else if (adv) begin
            vld_a_reg <= s_tvalid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_a_reg   <= in_op;
            wsel_a_reg <= in_wsel;
            tsel_a_reg <= in_tsel;
            sa_a_reg   <= in_sa;
            sb_a_reg   <= in_sb;
            bz_a_reg   <= bz_next;
            sdo_a_reg  <= sdo_next;
            dvd_a_reg  <= dvd_next;
            dvs_a_reg  <= dvs_next;
            a_a_reg    <= in_a;
            b_a_reg    <= in_b;
            mx_a_reg   <= mx_next;
            my_a_reg   <= my_next;
            // stages B and C: context catches up with the two-stage units
            op_b_reg   <= op_a_reg;
            wsel_b_reg <= wsel_a_reg;
            tsel_b_reg <= tsel_a_reg;
            sa_b_reg   <= sa_a_reg;
            sb_b_reg   <= sb_a_reg;
            bz_b_reg   <= bz_a_reg;
            sdo_b_reg  <= sdo_a_reg;
            dvd_b_reg  <= dvd_a_reg;
            dvs_b_reg  <= dvs_a_reg;
            op_c_reg   <= op_b_reg;
            wsel_c_reg <= wsel_b_reg;
            tsel_c_reg <= tsel_b_reg;
            sa_c_reg   <= sa_b_reg;
            sb_c_reg   <= sb_b_reg;
            bz_c_reg   <= bz_b_reg;
            sdo_c_reg  <= sdo_b_reg;
            dvd_c_reg  <= dvd_b_reg;
            dvs_c_reg  <= dvs_b_reg;
        end
    end

    // ---- stages B, C: misc ops and multiplier ----
    logic [DW-1:0] misc_r, prod_lo, prod_hi;
    logic          misc_ovf;

    wsia_logic u_logic (
        .aclk (aclk),
        .en   (adv),
        .op   (op_a_reg),
        .wsel (wsel_a_reg),
        .tsel (tsel_a_reg),
        .a    (a_a_reg),
        .b    (b_a_reg),
        .sa   (sa_a_reg),
        .sb   (sb_a_reg),
        .res  (misc_r),
        .ovf  (misc_ovf)
    );

    wsia_mul u_mul (
        .aclk (aclk),
        .en   (adv),
        .x    (mx_a_reg),
        .y    (my_a_reg),
        .lo   (prod_lo),
        .hi   (prod_hi)
    );

    // ---- divider stages ----
    wsia_pkg::ctx_t ctx_c, ctx_d;
    logic           div_vld;
    logic [DW-1:0]  div_q, div_r;

    always_comb begin
        ctx_c.op       = op_c_reg;
        ctx_c.wsel     = wsel_c_reg;
        ctx_c.tsel     = tsel_c_reg;
        ctx_c.sa       = sa_c_reg;
        ctx_c.sb       = sb_c_reg;
        ctx_c.bzero    = bz_c_reg;
        ctx_c.sdiv_ovf = sdo_c_reg;
        ctx_c.misc_r   = misc_r;
        ctx_c.misc_ovf = misc_ovf;
        ctx_c.prod_lo  = prod_lo;
        ctx_c.prod_hi  = prod_hi;
    end

    wsia_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_vld  (vld_c_reg),
        .dvd     (dvd_c_reg),
        .dvs     (dvs_c_reg),
        .ctx_in  (ctx_c),
        .out_vld (div_vld),
        .quo     (div_q),
        .rem     (div_r),
        .ctx_out (ctx_d)
    );

    // ---- final stage: sign fix, saturation, result width ----
    logic [DW-1:0] f_m, f_smin, f_smax, f_lim, mul_wrap, q_s, r_s, res_raw, res_next;
    logic          f_neg, smul_ovf, umul_ovf, ovf_next, dz_next;
    logic [1:0]    rw_sel;

    always_comb begin
        f_m      = wsia_pkg::mask_of(ctx_d.wsel);
        f_smin   = wsia_pkg::smin_of(ctx_d.wsel);
        f_smax   = wsia_pkg::smax_of(ctx_d.wsel);
        f_neg    = ctx_d.sa ^ ctx_d.sb;
        f_lim    = f_neg ? f_smin : f_smax;
        smul_ovf = (ctx_d.prod_hi != '0) || (ctx_d.prod_lo > f_lim);
        umul_ovf = (ctx_d.prod_hi != '0) || (ctx_d.prod_lo > f_m);
        mul_wrap = (f_neg ? (DW'(0) - ctx_d.prod_lo) : ctx_d.prod_lo) & f_m;
        q_s      = (f_neg ? (DW'(0) - div_q) : div_q) & f_m;
        r_s      = (ctx_d.sa ? (DW'(0) - div_r) : div_r) & f_m;
        res_raw  = '0;
        ovf_next = 1'b0;
        dz_next  = 1'b0;
        case (ctx_d.op)
            wsia_pkg::OP_MUL: begin
                res_raw  = mul_wrap;
                ovf_next = smul_ovf;
            end
            wsia_pkg::OP_SMUL_SAT: begin
                ovf_next = smul_ovf;
                res_raw  = smul_ovf ? f_lim : mul_wrap;
            end
            wsia_pkg::OP_UMUL_SAT: begin
                ovf_next = umul_ovf;
                res_raw  = umul_ovf ? f_m : ctx_d.prod_lo;
            end
            wsia_pkg::OP_SDIV: begin
                dz_next  = ctx_d.bzero;
                ovf_next = !ctx_d.bzero && ctx_d.sdiv_ovf;
                res_raw  = ctx_d.bzero ? '0 : q_s;
            end
            wsia_pkg::OP_SDIV_SAT: begin
                dz_next  = ctx_d.bzero;
                ovf_next = !ctx_d.bzero && ctx_d.sdiv_ovf;
                res_raw  = ctx_d.bzero ? '0 : (ctx_d.sdiv_ovf ? f_smax : q_s);
            end
            wsia_pkg::OP_SREM: begin
                dz_next = ctx_d.bzero;
                res_raw = ctx_d.bzero ? '0 : r_s;
            end
            wsia_pkg::OP_UDIV: begin
                dz_next = ctx_d.bzero;
                res_raw = ctx_d.bzero ? '0 : div_q;
            end
            wsia_pkg::OP_UREM: begin
                dz_next = ctx_d.bzero;
                res_raw = ctx_d.bzero ? '0 : div_r;
            end
            default: begin
                res_raw  = ctx_d.misc_r;
                ovf_next = ctx_d.misc_ovf;
            end
        endcase
        // convert ops size to the target width
        rw_sel   = (ctx_d.op inside {[wsia_pkg::OP_TRUNC_SSAT : wsia_pkg::OP_SEXT]})
                   ? ctx_d.tsel : ctx_d.wsel;
        res_next = res_raw & wsia_pkg::mask_of(rw_sel);
    end

    logic          m_vld_reg, m_ovf_reg, m_dz_reg;
    logic [DW-1:0] m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_res_reg <= res_next;
            m_ovf_reg <= ovf_next;
            m_dz_reg  <= dz_next;
        end
    end

    assign adv      = !m_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {(wsia_pkg::M_TDATA_W - DW - 2)'(0), m_dz_reg, m_ovf_reg, m_res_reg};

    // ---- assertions ----
    a_dz_no_ovf : assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && m_dz_reg |-> !m_ovf_reg)
        else $error("div_zero with overflow set");

    a_dz_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && m_dz_reg |-> m_res_reg == '0)
        else $error("div_zero with nonzero result");

    a_pipe_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(div_vld) && $stable(div_q))
        else $error("divider moved during stall");

endmodule

`default_nettype wire

// ===== dv/tb_width_selectable_integer_alu.sv =====
// ----------------------------------------------------------------------------
// tb_width_selectable_integer_alu: self-checking stream testbench
// Drives opcode/width/operand beats, predicts each result in a local ALU
// model and checks every output beat in order, with random bursts and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_width_selectable_integer_alu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 68;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RAND_ITEMS  = 1300;
    localparam int S_TDATA_W   = wsia_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = wsia_pkg::M_TDATA_W;

    typedef struct packed {
        logic [63:0] value;
        logic        ovf;
        logic        dz;
    } alu_res_t;

    typedef struct {
        logic [5:0]  op;
        logic [1:0]  wsel;
        logic [63:0] a;
        logic [63:0] b;
        logic [1:0]  tsel;
        logic        known;   // expected value typed in the table
        alu_res_t    res;
    } vec_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    alu_res_t expected_q[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       stim_done = 1'b0;
    bit       long_hold = 1'b0;   // receiver holds off while sender keeps going

    width_selectable_integer_alu u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---- predictor helpers --------------------------------------------------
    function automatic int bits_of(logic [1:0] sel);
        int w;
        w = 8 << sel;
        return (w > wsia_pkg::MAX_WIDTH) ? wsia_pkg::MAX_WIDTH : w;
    endfunction

    function automatic logic [63:0] wmask(int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic sign_bit(logic [63:0] v, int w);
        return v[w-1];
    endfunction

    function automatic logic [63:0] sx(logic [63:0] v, int w);
        v &= wmask(w);
        return sign_bit(v, w) ? (v | ~wmask(w)) : v;
    endfunction

    function automatic logic [63:0] magnitude(logic [63:0] v, int w);
        logic [63:0] e;
        e = sx(v, w);
        return sign_bit(v, w) ? (64'd0 - e) : e;
    endfunction

    function automatic int lead_zeros(logic [63:0] v, int w);
        int n;
        n = 0;
        while (n < w && v[w-1-n] == 1'b0) n++;
        return n;
    endfunction

    function automatic int trail_zeros(logic [63:0] v, int w);
        int n;
        n = 0;
        while (n < w && v[n] == 1'b0) n++;
        return n;
    endfunction

    function automatic logic shl_lost(logic [63:0] a, logic [63:0] c, int w);
        if (c >= w) return a != 0;
        if (sign_bit(a, w)) return c >= lead_zeros(~a & wmask(w), w);
        return a != 0 && c >= lead_zeros(a, w);
    endfunction

    // Expected result of one ALU beat.
    function automatic alu_res_t alu_predict(logic [5:0] opc, logic [1:0] wsel,
                                             logic [63:0] ain, logic [63:0] bin,
                                             logic [1:0] tsel);
        int          w, t, rw;
        logic [63:0] m, a, b, r, ea, eb, q, smax, smin, sra;
        logic signed [63:0] sea;
        logic [127:0] prod;
        logic        sa, sb, ovf, dz, neg;
        alu_res_t    res;
        w = bits_of(wsel); t = bits_of(tsel); rw = w;
        m = wmask(w); a = ain & m; b = bin & m;
        ea = sx(a, w); eb = sx(b, w);
        sea = ea;
        sa = sign_bit(a, w); sb = sign_bit(b, w);
        smax = m >> 1; smin = 64'd1 << (w - 1);
        r = '0; ovf = 1'b0; dz = 1'b0;
        case (opc)
            wsia_pkg::OP_ADD, wsia_pkg::OP_SADD_SAT: begin
                r = (a + b) & m;
                ovf = (sa == sb) && (sign_bit(r, w) != sa);
                if (opc == wsia_pkg::OP_SADD_SAT && ovf) r = sa ? smin : smax;
            end
            wsia_pkg::OP_SUB, wsia_pkg::OP_SSUB_SAT: begin
                r = (a - b) & m;
                ovf = (sa != sb) && (sign_bit(r, w) != sa);
                if (opc == wsia_pkg::OP_SSUB_SAT && ovf) r = sa ? smin : smax;
            end
            wsia_pkg::OP_MUL, wsia_pkg::OP_SMUL_SAT: begin
                r = (a * b) & m;
                prod = {64'd0, magnitude(a, w)} * {64'd0, magnitude(b, w)};
                neg = sa != sb;
                ovf = (prod[127:64] != 0) || (prod[63:0] > (neg ? smin : smax));
                if (opc == wsia_pkg::OP_SMUL_SAT && ovf) r = neg ? smin : smax;
            end
            wsia_pkg::OP_SDIV, wsia_pkg::OP_SREM, wsia_pkg::OP_SDIV_SAT: begin
                if (b == 0) dz = 1'b1;
                else if (opc == wsia_pkg::OP_SREM) begin
                    q = magnitude(a, w) % magnitude(b, w);
                    r = (sa ? 64'd0 - q : q) & m;
                end else begin
                    q = magnitude(a, w) / magnitude(b, w);
                    r = ((sa != sb) ? 64'd0 - q : q) & m;
                    ovf = (a == smin) && (b == m);
                    if (opc == wsia_pkg::OP_SDIV_SAT && ovf) r = smax;
                end
            end
            wsia_pkg::OP_UDIV: if (b == 0) dz = 1'b1; else r = a / b;
            wsia_pkg::OP_UREM: if (b == 0) dz = 1'b1; else r = a % b;
            wsia_pkg::OP_AND: r = a & b;
            wsia_pkg::OP_OR:  r = a | b;
            wsia_pkg::OP_XOR: r = a ^ b;
            wsia_pkg::OP_NEG: begin r = (64'd0 - a) & m; ovf = a == smin; end
            wsia_pkg::OP_SHL, wsia_pkg::OP_SSHL_SAT: begin
                r = (b >= w) ? 64'd0 : (a << b) & m;
                ovf = shl_lost(a, b, w);
                if (opc == wsia_pkg::OP_SSHL_SAT && ovf) r = sa ? smin : smax;
            end
            wsia_pkg::OP_LSHR: r = (b >= w) ? 64'd0 : a >> b;
            wsia_pkg::OP_ASHR: begin
                sra = sea >>> b;   // sign fill at every width, 64 included
                r = (b >= w) ? (sa ? m : 64'd0) : (sra & m);
            end
            wsia_pkg::OP_UADD_SAT: begin
                r = (a + b) & m;
                if (r < b) begin ovf = 1'b1; r = m; end
            end
            wsia_pkg::OP_USUB_SAT: if (b > a) ovf = 1'b1; else r = a - b;
            wsia_pkg::OP_UMUL_SAT: begin
                prod = {64'd0, a} * {64'd0, b};
                ovf = (prod[127:64] != 0) || (prod[63:0] > m);
                r = ovf ? m : prod[63:0];
            end
            wsia_pkg::OP_USHL_SAT: begin
                if (b >= w) ovf = a != 0;
                else ovf = b > lead_zeros(a, w);
                r = ovf ? m : ((b >= w) ? 64'd0 : (a << b) & m);
            end
            wsia_pkg::OP_SCMP: r = ($signed(ea) < $signed(eb)) ? m :
                                   (($signed(eb) < $signed(ea)) ? 64'd1 : 64'd0);
            wsia_pkg::OP_UCMP: r = (a < b) ? m : ((a > b) ? 64'd1 : 64'd0);
            wsia_pkg::OP_SMIN: r = ($signed(eb) < $signed(ea)) ? b : a;
            wsia_pkg::OP_UMIN: r = (b < a) ? b : a;
            wsia_pkg::OP_SMAX: r = ($signed(ea) < $signed(eb)) ? b : a;
            wsia_pkg::OP_UMAX: r = (a < b) ? b : a;
            wsia_pkg::OP_TRUNC_SSAT: begin
                rw = t;
                if (t >= 64 || sx(ea, t) == ea) r = ea & wmask(t);
                else begin
                    ovf = 1'b1;
                    r = sa ? (64'd1 << (t - 1)) : (wmask(t) >> 1);
                end
            end
            wsia_pkg::OP_TRUNC_USAT: begin
                rw = t;
                if (a <= wmask(t)) r = a;
                else begin ovf = 1'b1; r = wmask(t); end
            end
            wsia_pkg::OP_ZEXT: begin rw = t; r = a & wmask(t); end
            wsia_pkg::OP_SEXT: begin rw = t; r = ea & wmask(t); end
            wsia_pkg::OP_CLZ:      r = 64'(lead_zeros(a, w));
            wsia_pkg::OP_CLO:      r = 64'(lead_zeros(~a & m, w));
            wsia_pkg::OP_CTZ:      r = 64'(trail_zeros(a, w));
            wsia_pkg::OP_POPCOUNT: r = 64'($countones(a));
            default: r = '0;   // unassigned codes give all zero
        endcase
        res.value = r & wmask(rw);
        res.ovf   = ovf;
        res.dz    = dz;
        return res;
    endfunction

    // ---- directed table -----------------------------------------------------
    localparam logic [63:0] ONES = '1;
    vec_t directed[$];

    function automatic vec_t row(logic [5:0] opc, logic [1:0] wsel, logic [63:0] a,
                                 logic [63:0] b, logic [1:0] tsel, logic known,
                                 logic [63:0] value, logic ovf, logic dz);
        vec_t v;
        v.op = opc; v.wsel = wsel; v.a = a; v.b = b; v.tsel = tsel;
        v.known = known; v.res = '{value, ovf, dz};
        return v;
    endfunction

    initial begin
        // extremes and error codes with values typed in
        directed.push_back(row(wsia_pkg::OP_ADD, 2'd3, ONES, ONES, 2'd0,
                               1'b1, ONES - 64'd1, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_ADD, 2'd0, 64'h7f, 64'h1, 2'd0,
                               1'b1, 64'h80, 1'b1, 1'b0));
        directed.push_back(row(wsia_pkg::OP_SDIV, 2'd1, 64'h1234, 64'h0, 2'd0,
                               1'b1, 64'd0, 1'b0, 1'b1));
        directed.push_back(row(wsia_pkg::OP_UDIV, 2'd3, ONES, 64'h0, 2'd0,
                               1'b1, 64'd0, 1'b0, 1'b1));
        directed.push_back(row(wsia_pkg::OP_SREM, 2'd2, 64'h5, 64'h0, 2'd0,
                               1'b1, 64'd0, 1'b0, 1'b1));
        directed.push_back(row(wsia_pkg::OP_UREM, 2'd0, 64'h5, 64'h100, 2'd0,
                               1'b1, 64'd0, 1'b0, 1'b1));
        directed.push_back(row(wsia_pkg::OP_SDIV_SAT, 2'd0, 64'h9, 64'h0, 2'd0,
                               1'b1, 64'd0, 1'b0, 1'b1));
        // minimum divided by minus one
        directed.push_back(row(wsia_pkg::OP_SDIV, 2'd0, 64'h80, 64'hff, 2'd0,
                               1'b1, 64'h80, 1'b1, 1'b0));
        directed.push_back(row(wsia_pkg::OP_SREM, 2'd3, 64'h8000_0000_0000_0000, ONES,
                               2'd0, 1'b1, 64'd0, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_SDIV_SAT, 2'd1, 64'h8000, 64'hffff, 2'd0,
                               1'b1, 64'h7fff, 1'b1, 1'b0));
        // large shift counts, zero a on saturating shift
        directed.push_back(row(wsia_pkg::OP_SHL, 2'd0, 64'h1, 64'h8, 2'd0,
                               1'b1, 64'd0, 1'b1, 1'b0));
        directed.push_back(row(wsia_pkg::OP_ASHR, 2'd1, 64'h8000, 64'h40, 2'd0,
                               1'b1, 64'hffff, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_SSHL_SAT, 2'd2, 64'h0, 64'hffff_ffff, 2'd0,
                               1'b1, 64'd0, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_USHL_SAT, 2'd2, 64'h1, 64'h40, 2'd0,
                               1'b1, 64'hffff_ffff, 1'b1, 1'b0));
        directed.push_back(row(wsia_pkg::OP_SSHL_SAT, 2'd0, 64'hf0, 64'h7, 2'd0,
                               1'b0, 64'd0, 1'b0, 1'b0));
        // full-width arithmetic shift of a negative value
        directed.push_back(row(wsia_pkg::OP_ASHR, 2'd3, 64'h8000_0000_0000_0000, 64'h4,
                               2'd0, 1'b1, 64'hf800_0000_0000_0000, 1'b0, 1'b0));
        // compare gives all ones in w bits
        directed.push_back(row(wsia_pkg::OP_SCMP, 2'd0, 64'h80, 64'h7f, 2'd0,
                               1'b1, 64'hff, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_UCMP, 2'd3, 64'h0, ONES, 2'd0,
                               1'b1, ONES, 1'b0, 1'b0));
        // truncate and extend across widths
        directed.push_back(row(wsia_pkg::OP_TRUNC_SSAT, 2'd0, 64'h80, 64'h0, 2'd3,
                               1'b1, ONES - 64'd127, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_TRUNC_USAT, 2'd3, ONES, 64'h0, 2'd0,
                               1'b1, 64'hff, 1'b1, 1'b0));
        directed.push_back(row(wsia_pkg::OP_SEXT, 2'd3, ONES, 64'h0, 2'd1,
                               1'b1, 64'hffff, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_ZEXT, 2'd0, ONES, 64'h0, 2'd3,
                               1'b1, 64'hff, 1'b0, 1'b0));
        // bit counts, ctz of zero
        directed.push_back(row(wsia_pkg::OP_CTZ, 2'd3, 64'h0, 64'h0, 2'd0,
                               1'b1, 64'd64, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_CLO, 2'd1, ONES, 64'h0, 2'd0,
                               1'b1, 64'd16, 1'b0, 1'b0));
        directed.push_back(row(wsia_pkg::OP_POPCOUNT, 2'd3, ONES, ONES, 2'd3,
                               1'b1, 64'd64, 1'b0, 1'b0));
        directed.push_back(row(6'd63, 2'd3, ONES, ONES, 2'd3,
                               1'b1, 64'd0, 1'b0, 1'b0));
    end

    // ---- random operands biased toward corners ------------------------------
    function automatic logic [63:0] pick_operand(logic [1:0] wsel);
        logic [63:0] m;
        m = wmask(bits_of(wsel));
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return ONES;
            2: return m >> 1;
            3: return (m >> 1) + 64'd1;
            4: return 64'($urandom_range(0, 3));
            5: return 64'($urandom_range(0, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one beat: hold tvalid until accepted, then keep it high if another follows
    task automatic send_beat(logic [5:0] opc, logic [1:0] wsel, logic [63:0] a,
                             logic [63:0] b, logic [1:0] tsel);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({tsel, b, a, wsel, opc});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic sender_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // ---- scoreboard: record expectation on every accepted input beat --------
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_q.push_back(alu_predict(s_tdata[5:0], s_tdata[7:6], s_tdata[71:8],
                                             s_tdata[135:72], s_tdata[137:136]));
        end
    end

    // ---- check output beats in order ----------------------------------------
    always @(posedge aclk) begin
        alu_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[63:0] !== want.value || m_tdata[64] !== want.ovf
                    || m_tdata[65] !== want.dz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value=%h ovf=%b dz=%b, got %h %b %b",
                                 want.value, want.ovf, want.dz,
                                 m_tdata[63:0], m_tdata[64], m_tdata[65]);
                end
            end
        end
    end

    // ---- receiver stall pattern plus one long hold ---------------------------
    always @(posedge aclk) begin
        if (!aresetn || long_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 7) > 1) || stim_done;
    end

    initial begin
        @(posedge aresetn);
        repeat (200) @(posedge aclk);
        long_hold = 1'b1;
        repeat (300) @(posedge aclk);   // pipe fills, s_tready must drop
        long_hold = 1'b0;
    end

    // ---- watchdog: cycles with no handshake on either side -------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** width_selectable_integer_alu: FAILED **");
            $finish;
        end
    end

    // ---- main stimulus ---------------------------------------------------------
    initial begin
        alu_res_t got;
        logic [5:0] opc;
        logic [1:0] wsel;
        int drain;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            got = alu_predict(directed[i].op, directed[i].wsel, directed[i].a,
                              directed[i].b, directed[i].tsel);
            if (directed[i].known && got !== directed[i].res) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: typed %h, predictor %h", i,
                             directed[i].res, got);
            end
            send_beat(directed[i].op, directed[i].wsel, directed[i].a,
                      directed[i].b, directed[i].tsel);
            sender_gap();
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            opc  = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(37, 63))
                                                : 6'($urandom_range(0, 36));
            wsel = 2'($urandom_range(0, 3));
            send_beat(opc, wsel, pick_operand(wsel), pick_operand(wsel),
                      2'($urandom_range(0, 3)));
            if ($urandom_range(0, 15) == 0) sender_gap();
            else if ($urandom_range(0, 31) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        drain = 0;
        while (expected_q.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("** width_selectable_integer_alu: PASSED **");
        end else begin
            $display("** width_selectable_integer_alu: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
